// ===== src/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants of the helicity-cosine block
// Status codes, per-item side information and dot-product slot numbering.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  localparam int COMPONENT_WIDTH_DEF = 32;
  localparam int COS_FRAC_BITS_DEF   = 30;

  // register stages of the limb-split wide multiplier
  localparam int MUL_STAGES = 5;

  // Minkowski products formed per item
  localparam int NUM_DOTS  = 6;
  localparam int NUM_TERMS = 4;   // energy, x, y, z
  localparam int DOT_M2    = 0;   // D.D
  localparam int DOT_AD    = 1;   // A.D
  localparam int DOT_BD    = 2;   // B.D
  localparam int DOT_AB    = 3;   // A.B
  localparam int DOT_AA    = 4;   // A.A
  localparam int DOT_BB    = 5;   // B.B

  // four-vector slots inside the input word
  localparam int VEC_MOTHER   = 0;
  localparam int VEC_DAUGHTER = 1;
  localparam int VEC_GRAND    = 2;
  localparam int NUM_VECS     = 3;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_TIMELIKE = 2'd1,
    ST_ZERO_MOM     = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    negn;     // sign of the invariant numerator N
  } meta_t;

endpackage

`default_nettype wire

// ===== src/chd_dots.sv =====
// ----------------------------------------------------------------------------
// chd_dots: Minkowski dot products
// Unpack three four-vectors, multiply term pairs, then sum into six products.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_dots #(
  parameter int COMPONENT_WIDTH = chd_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [12*COMPONENT_WIDTH-4:0]     in_data,
  output logic                              dot_valid,
  output logic signed [2*COMPONENT_WIDTH+1:0] dot_val [chd_pkg::NUM_DOTS]
);
  import chd_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int VW = 4 * W - 1;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 2;

  localparam int VEC_L [NUM_DOTS] = '{VEC_DAUGHTER, VEC_MOTHER, VEC_GRAND,
                                      VEC_MOTHER, VEC_MOTHER, VEC_GRAND};
  localparam int VEC_R [NUM_DOTS] = '{VEC_DAUGHTER, VEC_DAUGHTER, VEC_DAUGHTER,
                                      VEC_GRAND, VEC_MOTHER, VEC_GRAND};

  logic signed [W-1:0]  comp [NUM_VECS][NUM_TERMS];
  logic signed [PW-1:0] prod_r [NUM_DOTS][NUM_TERMS];
  logic                 prod_valid_r;
  logic signed [DW-1:0] dot_r [NUM_DOTS];
  logic                 dot_valid_r;

  always_comb begin
    for (int v = 0; v < NUM_VECS; v++) begin
      comp[v][0] = $signed({1'b0, in_data[v*VW+3*W +: W-1]});
      comp[v][1] = $signed(in_data[v*VW +: W]);
      comp[v][2] = $signed(in_data[v*VW+W +: W]);
      comp[v][3] = $signed(in_data[v*VW+2*W +: W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_DOTS; k++) begin
        for (int c = 0; c < NUM_TERMS; c++) begin
          prod_r[k][c] <= comp[VEC_L[k]][c] * comp[VEC_R[k]][c];
        end
        dot_r[k] <= DW'(prod_r[k][0]) - DW'(prod_r[k][1])
                  - DW'(prod_r[k][2]) - DW'(prod_r[k][3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      dot_valid_r  <= 1'b0;
    end else if (en) begin
      prod_valid_r <= in_valid;
      dot_valid_r  <= prod_valid_r;
    end
  end

  assign dot_valid = dot_valid_r;
  assign dot_val   = dot_r;

endmodule

`default_nettype wire

// ===== src/chd_invar.sv =====
// ----------------------------------------------------------------------------
// chd_invar: invariants N, QA, QB and the division operands
// Pipelined cross products, one stage of differences and status, then
// pipelined N^2 and QA*QB products; wide products are split into 32-bit limbs.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_mul #(
  parameter int AW         = 66,
  parameter bit SIGNED_OPS = 1'b1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [AW-1:0]   b,
  output logic [2*AW-1:0] p
);
  localparam int LW = 32;
  localparam int NL = (AW + LW - 1) / LW;
  localparam int EW = NL * LW;
  localparam int PW = 2 * AW;

  logic [AW-1:0]   am, bm;
  logic            neg;
  logic [EW-1:0]   am_r, bm_r;
  logic [3:0]      neg_r;
  logic [2*LW-1:0] pp_r [NL][NL];
  logic [PW-1:0]   row_nxt [NL];
  logic [PW-1:0]   row_r [NL];
  logic [PW-1:0]   sum_nxt;
  logic [PW-1:0]   sum_r, p_r;

  // sign and magnitude
  always_comb begin
    if (SIGNED_OPS) begin
      am  = a[AW-1] ? -a : a;
      bm  = b[AW-1] ? -b : b;
      neg = a[AW-1] ^ b[AW-1];
    end else begin
      am  = a;
      bm  = b;
      neg = 1'b0;
    end
  end

  // sum limb products per row, then the rows
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_nxt[i] = row_nxt[i] + (PW'(pp_r[i][j]) << (j * LW));
      end
    end
    sum_nxt = '0;
    for (int i = 0; i < NL; i++) begin
      sum_nxt = sum_nxt + (row_r[i] << (i * LW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= EW'(am);
      bm_r  <= EW'(bm);
      neg_r <= {neg_r[2:0], neg};
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp_r[i][j] <= am_r[i*LW +: LW] * bm_r[j*LW +: LW];
        end
      end
      row_r <= row_nxt;
      sum_r <= sum_nxt;
      p_r   <= neg_r[3] ? -sum_r : sum_r;
    end
  end

  assign p = p_r;

endmodule

module chd_invar #(
  parameter int COMPONENT_WIDTH = chd_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                dot_valid,
  input  logic signed [2*COMPONENT_WIDTH+1:0] dot_val [chd_pkg::NUM_DOTS],
  output logic                                op_valid,
  output logic [8*COMPONENT_WIDTH+9:0]        op_n2,
  output logic [8*COMPONENT_WIDTH+9:0]        op_p,
  output chd_pkg::meta_t                      op_meta
);
  import chd_pkg::*;

  localparam int DW  = 2 * COMPONENT_WIDTH + 2;
  localparam int XW  = 2 * DW;
  localparam int NW  = XW + 1;
  localparam int SQW = 2 * NW;
  localparam int ML  = MUL_STAGES;

  // cross products: ad*bd, m2*ab, ad*ad, m2*aa, bd*bd, m2*bb
  logic [DW-1:0]        xa [6];
  logic [DW-1:0]        xb [6];
  logic [XW-1:0]        xp [6];
  logic                 m2pos;
  logic                 m2pos_d [ML];
  logic                 xp_vld_d [ML];

  logic signed [NW-1:0] n_nxt, qa_nxt, qb_nxt;
  logic [NW-1:0]        absn_r, qa_r, qb_r;
  meta_t                meta_nxt, meta_r;
  logic                 diff_valid_r;

  logic [SQW-1:0]       n2, pq;
  meta_t                md_d [ML];
  logic                 sq_vld_d [ML];

  assign xa[0] = dot_val[DOT_AD];  assign xb[0] = dot_val[DOT_BD];
  assign xa[1] = dot_val[DOT_M2];  assign xb[1] = dot_val[DOT_AB];
  assign xa[2] = dot_val[DOT_AD];  assign xb[2] = dot_val[DOT_AD];
  assign xa[3] = dot_val[DOT_M2];  assign xb[3] = dot_val[DOT_AA];
  assign xa[4] = dot_val[DOT_BD];  assign xb[4] = dot_val[DOT_BD];
  assign xa[5] = dot_val[DOT_M2];  assign xb[5] = dot_val[DOT_BB];

  assign m2pos = !dot_val[DOT_M2][DW-1] && (dot_val[DOT_M2] != '0);

  for (genvar k = 0; k < 6; k++) begin : g_xp
    chd_mul #(
      .AW         (DW),
      .SIGNED_OPS (1'b1)
    ) u_mul (
      .clk (clk),
      .en  (en),
      .a   (xa[k]),
      .b   (xb[k]),
      .p   (xp[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2pos_d[0] <= m2pos;
      for (int s = 1; s < ML; s++) begin
        m2pos_d[s] <= m2pos_d[s-1];
      end
    end
  end

  always_comb begin
    n_nxt  = NW'($signed(xp[0])) - NW'($signed(xp[1]));
    qa_nxt = NW'($signed(xp[2])) - NW'($signed(xp[3]));
    qb_nxt = NW'($signed(xp[4])) - NW'($signed(xp[5]));
    meta_nxt.negn = n_nxt[NW-1];
    if (!m2pos_d[ML-1]) begin
      meta_nxt.status = ST_NOT_TIMELIKE;
    end else if (qa_nxt == '0 || qb_nxt == '0) begin
      meta_nxt.status = ST_ZERO_MOM;
    end else begin
      meta_nxt.status = ST_OK;
    end
  end

  // QA and QB are never negative for a timelike daughter; force a safe divisor otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (meta_nxt.status == ST_OK) begin
        absn_r <= n_nxt[NW-1] ? $unsigned(-n_nxt) : $unsigned(n_nxt);
        qa_r   <= $unsigned(qa_nxt);
        qb_r   <= $unsigned(qb_nxt);
      end else begin
        absn_r <= '0;
        qa_r   <= NW'(1);
        qb_r   <= NW'(1);
      end
      meta_r <= meta_nxt;
    end
  end

  chd_mul #(
    .AW         (NW),
    .SIGNED_OPS (1'b0)
  ) u_sq_n (
    .clk (clk),
    .en  (en),
    .a   (absn_r),
    .b   (absn_r),
    .p   (n2)
  );

  chd_mul #(
    .AW         (NW),
    .SIGNED_OPS (1'b0)
  ) u_sq_p (
    .clk (clk),
    .en  (en),
    .a   (qa_r),
    .b   (qb_r),
    .p   (pq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      md_d[0] <= meta_r;
      for (int s = 1; s < ML; s++) begin
        md_d[s] <= md_d[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ML; s++) begin
        xp_vld_d[s] <= 1'b0;
        sq_vld_d[s] <= 1'b0;
      end
      diff_valid_r <= 1'b0;
    end else if (en) begin
      xp_vld_d[0] <= dot_valid;
      for (int s = 1; s < ML; s++) begin
        xp_vld_d[s] <= xp_vld_d[s-1];
      end
      diff_valid_r <= xp_vld_d[ML-1];
      sq_vld_d[0]  <= diff_valid_r;
      for (int s = 1; s < ML; s++) begin
        sq_vld_d[s] <= sq_vld_d[s-1];
      end
    end
  end

  assign op_valid = sq_vld_d[ML-1];
  assign op_n2    = n2;
  assign op_p     = pq;
  assign op_meta  = md_d[ML-1];

endmodule

`default_nettype wire

// ===== src/chd_div.sv =====
// ----------------------------------------------------------------------------
// chd_div: pipelined restoring divider
// Quotient floor(N^2 * 2^(2F+2) / (QA*QB)), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_div #(
  parameter int COMPONENT_WIDTH = chd_pkg::COMPONENT_WIDTH_DEF,
  parameter int COS_FRAC_BITS   = chd_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            op_valid,
  input  logic [8*COMPONENT_WIDTH+9:0]    op_n2,
  input  logic [8*COMPONENT_WIDTH+9:0]    op_p,
  input  chd_pkg::meta_t                  op_meta,
  output logic                            quo_valid,
  output logic [2*COS_FRAC_BITS+2:0]      quo,
  output chd_pkg::meta_t                  quo_meta
);
  import chd_pkg::*;

  localparam int PW = 8 * COMPONENT_WIDTH + 10;
  localparam int QW = 2 * COS_FRAC_BITS + 3;
  localparam int RW = PW + QW - 1;

  logic [RW-1:0] rem_r [QW-1];
  logic [PW-1:0] dv_r  [QW-1];
  logic [QW-1:0] quo_r [QW];
  meta_t         md_r  [QW];
  logic          vld_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [PW-1:0] dv_in;
    logic [QW-1:0] quo_in;
    meta_t         md_in;
    logic          vld_in;
    logic [RW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = {op_n2, {(QW-1){1'b0}}};
      assign dv_in  = op_p;
      assign quo_in = '0;
      assign md_in  = op_meta;
      assign vld_in = op_valid;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dv_in  = dv_r[i-1];
      assign quo_in = quo_r[i-1];
      assign md_in  = md_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    assign trial = RW'(dv_in) << (QW - 1 - i);
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i] <= quo_in | (ge ? (QW'(1) << (QW - 1 - i)) : '0);
        md_r[i]  <= md_in;
      end
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? (rem_in - trial) : rem_in;
          dv_r[i]  <= dv_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end
  end

  assign quo_valid = vld_r[QW-1];
  assign quo       = quo_r[QW-1];
  assign quo_meta  = md_r[QW-1];

endmodule

`default_nettype wire

// ===== src/chd_sqrt.sv =====
// ----------------------------------------------------------------------------
// chd_sqrt: pipelined integer square root and output stage
// One root bit per stage; then halve with rounding, clamp and apply sign.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_sqrt #(
  parameter int COS_FRAC_BITS = chd_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                quo_valid,
  input  logic [2*COS_FRAC_BITS+2:0]          quo,
  input  chd_pkg::meta_t                      quo_meta,
  output logic                                res_valid,
  output logic signed [COS_FRAC_BITS+1:0]     res_cos,
  output chd_pkg::status_t                    res_status
);
  import chd_pkg::*;

  localparam int F  = COS_FRAC_BITS;
  localparam int QW = 2 * F + 3;
  localparam int SW = F + 2;
  localparam int XW = QW + 2;
  localparam int CW = F + 2;

  logic [QW-1:0] q_r   [SW-1];
  logic [XW-1:0] s2_r  [SW-1];
  logic [SW-1:0] s_r   [SW];
  meta_t         md_r  [SW];
  logic          vld_r [SW];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    localparam int B = SW - 1 - j;
    logic [QW-1:0] q_in;
    logic [XW-1:0] s2_in;
    logic [SW-1:0] s_in;
    meta_t         md_in;
    logic          vld_in;
    logic [XW-1:0] t2;
    logic          le;

    if (j == 0) begin : g_first
      assign q_in   = quo;
      assign s2_in  = '0;
      assign s_in   = '0;
      assign md_in  = quo_meta;
      assign vld_in = quo_valid;
    end else begin : g_next
      assign q_in   = q_r[j-1];
      assign s2_in  = s2_r[j-1];
      assign s_in   = s_r[j-1];
      assign md_in  = md_r[j-1];
      assign vld_in = vld_r[j-1];
    end

    // (s + 2^B)^2 = s^2 + s * 2^(B+1) + 2^(2B)
    assign t2 = s2_in + (XW'(s_in) << (B + 1)) + (XW'(1) << (2 * B));
    assign le = (t2 <= XW'(q_in));

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j]  <= le ? (s_in | (SW'(1) << B)) : s_in;
        md_r[j] <= md_in;
      end
    end

    if (j < SW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          s2_r[j] <= le ? t2 : s2_in;
          q_r[j]  <= q_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end
  end

  logic [SW:0]             half;
  logic [CW-1:0]           mag;
  logic signed [CW-1:0]    cos_nxt;
  logic signed [CW-1:0]    cos_r;
  status_t                 status_r;
  logic                    out_valid_r;

  always_comb begin
    half = ((SW+1)'(s_r[SW-1]) + (SW+1)'(1)) >> 1;
    if (half > ((SW+1)'(1) << F)) begin
      mag = CW'(1) << F;
    end else begin
      mag = CW'(half);
    end
    if (md_r[SW-1].status != ST_OK) begin
      cos_nxt = '0;
    end else if (md_r[SW-1].negn) begin
      cos_nxt = $signed(mag);
    end else begin
      cos_nxt = -$signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r    <= cos_nxt;
      status_r <= md_r[SW-1].status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[SW-1];
    end
  end

  assign res_valid  = out_valid_r;
  assign res_cos    = cos_r;
  assign res_status = status_r;

endmodule

`default_nettype wire

// ===== src/cos_helicity_in_daughter_frame.sv =====
// ----------------------------------------------------------------------------
// cos_helicity_in_daughter_frame: helicity-angle cosine in the daughter frame
// Minus the cosine between mother and granddaughter momenta, boosted into the
// daughter rest frame, computed exactly from Minkowski invariants.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake         | contents
//  --------+-----+-------------------+------------------------------------------
//  in_     | in  | tvalid / tready   | mother, daughter, grand four-vectors
//  out_    | out | tvalid / tready   | cos_angle (tdata), status (tuser)
//
//  One transfer in per cycle while in_tready is high, one result per item, in order.
//  Stages in order: 2 dot-product stages, 11 invariant stages (two 5-stage
//  limb multipliers around one difference stage), the bit-per-stage divider
//  (2F+3 stages), the square root (F+2 stages) and the output register.
//  Reset (rst_n low, synchronous) clears every stage valid bit; data is not reset.
//  Stalls: when the output holds an untaken result, every stage holds and
//  in_tready drops in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module cos_helicity_in_daughter_frame #(
  parameter int COMPONENT_WIDTH = chd_pkg::COMPONENT_WIDTH_DEF,
  parameter int COS_FRAC_BITS   = chd_pkg::COS_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // from bit 0: mother_px, mother_py, mother_pz, mother_energy,
  // daughter_px, daughter_py, daughter_pz, daughter_energy,
  // grand_px, grand_py, grand_pz, grand_energy, zero fill
  input  logic [((12*COMPONENT_WIDTH+4)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // from bit 0: cos_angle (signed Q2.F), zero fill
  output logic [((COS_FRAC_BITS+9)/8)*8-1:0] out_tdata,
  // from bit 0: status
  output logic [1:0] out_tuser
);
  import chd_pkg::*;

  localparam int W      = COMPONENT_WIDTH;
  localparam int DW     = 2 * W + 2;
  localparam int PW     = 8 * W + 10;
  localparam int QW     = 2 * COS_FRAC_BITS + 3;
  localparam int CW     = COS_FRAC_BITS + 2;
  localparam int OUT_DW = ((COS_FRAC_BITS + 9) / 8) * 8;

  // global advance: the output register is free or being drained
  logic en;

  logic                 dot_valid;
  logic signed [DW-1:0] dot_val [NUM_DOTS];
  logic                 op_valid;
  logic [PW-1:0]        op_n2, op_p;
  meta_t                op_meta;
  logic                 quo_valid;
  logic [QW-1:0]        quo;
  meta_t                quo_meta;
  logic                 res_valid;
  logic signed [CW-1:0] res_cos;
  status_t              res_status;

  assign en        = out_tready || !res_valid;
  assign in_tready = en;

  // dot products of all pairs of four-vectors
  chd_dots #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_dots (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata[12*W-4:0]),
    .dot_valid (dot_valid),
    .dot_val   (dot_val)
  );

  // N, QA, QB, status and the divider operands N^2 and QA*QB
  chd_invar #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_invar (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .dot_valid (dot_valid),
    .dot_val   (dot_val),
    .op_valid  (op_valid),
    .op_n2     (op_n2),
    .op_p      (op_p),
    .op_meta   (op_meta)
  );

  // quotient of 4 N^2 2^(2F) by QA*QB
  chd_div #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .COS_FRAC_BITS   (COS_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .op_valid  (op_valid),
    .op_n2     (op_n2),
    .op_p      (op_p),
    .op_meta   (op_meta),
    .quo_valid (quo_valid),
    .quo       (quo),
    .quo_meta  (quo_meta)
  );

  // root, round half away from zero, sign, output register
  chd_sqrt #(
    .COS_FRAC_BITS (COS_FRAC_BITS)
  ) u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .quo_valid  (quo_valid),
    .quo        (quo),
    .quo_meta   (quo_meta),
    .res_valid  (res_valid),
    .res_cos    (res_cos),
    .res_status (res_status)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = OUT_DW'($unsigned(res_cos));
  assign out_tuser  = res_status;

endmodule

`default_nettype wire

// ===== src/chd_checker.sv =====
// ----------------------------------------------------------------------------
// chd_checker: port-level checks for the helicity-cosine block
// Output hold under stall, status and value consistency, ready behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_checker #(
  parameter int COS_FRAC_BITS   = chd_pkg::COS_FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((COS_FRAC_BITS+9)/8)*8-1:0] out_tdata,
  input logic [1:0] out_tuser
);
  import chd_pkg::*;

  localparam int F = COS_FRAC_BITS;

  logic signed [F+1:0] cos_w;
  assign cos_w = $signed(out_tdata[F+1:0]);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // error results carry a zero cosine
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> cos_w == '0)
    else $error("nonzero cosine on error status");

  // status is a defined code and the cosine stays in [-1, 1]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOT_TIMELIKE ||
                    out_tuser == ST_ZERO_MOM) &&
                   cos_w <= $signed((F+2)'(1) << F) && cos_w >= -$signed((F+2)'(1) << F))
    else $error("result out of range");

endmodule

bind cos_helicity_in_daughter_frame chd_checker #(
  .COS_FRAC_BITS   (COS_FRAC_BITS)
) u_chd_checker (.*);

`default_nettype wire
